### hdl/rpa_pkg.sv
package rpa_pkg;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx REG_QUAT_W   = 3'd0;
    localparam t_cfg_idx REG_QUAT_X   = 3'd1;
    localparam t_cfg_idx REG_QUAT_Y   = 3'd2;
    localparam t_cfg_idx REG_QUAT_Z   = 3'd3;
    localparam t_cfg_idx REG_OFFSET_X = 3'd4;
    localparam t_cfg_idx REG_OFFSET_Y = 3'd5;
    localparam t_cfg_idx REG_OFFSET_Z = 3'd6;

    // Quaternion component selects.
    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;

    localparam int         COEF_W   = 36;
    localparam logic [4:0] MAT_LAST = 5'd23;

    typedef logic [3:0][31:0]       t_quat;
    typedef logic [8:0][COEF_W-1:0] t_mat;

    typedef struct packed {
        logic [32:0] s_x;
        logic [32:0] s_y;
        logic [32:0] s_z;
        logic        last;
    } t_sum_item;

    typedef struct packed {
        logic      valid;
        t_sum_item item;
    } t_q_head;

    typedef struct packed {
        logic [31:0] min_x;
        logic [31:0] min_y;
        logic [31:0] min_z;
        logic [31:0] max_x;
        logic [31:0] max_y;
        logic [31:0] max_z;
    } t_box;

    // One step of the coefficient engine: product of two components,
    // added or subtracted into the coefficient named by idx.
    typedef struct packed {
        logic [1:0] sel_a;
        logic [1:0] sel_b;
        logic       neg;
        logic [3:0] idx;
        logic       last;
        logic       twice;
    } t_mstep;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MUL,
        BK_RND,
        BK_UPD
    } t_back_state;

    function automatic t_mstep mat_step(input logic [4:0] k);
        t_mstep s;
        unique case (k)
            5'd0:    s = '{Q_W, Q_W, 1'b0, 4'd0, 1'b0, 1'b0};
            5'd1:    s = '{Q_X, Q_X, 1'b0, 4'd0, 1'b0, 1'b0};
            5'd2:    s = '{Q_Y, Q_Y, 1'b1, 4'd0, 1'b0, 1'b0};
            5'd3:    s = '{Q_Z, Q_Z, 1'b1, 4'd0, 1'b1, 1'b0};
            5'd4:    s = '{Q_X, Q_Y, 1'b0, 4'd1, 1'b0, 1'b1};
            5'd5:    s = '{Q_W, Q_Z, 1'b0, 4'd1, 1'b1, 1'b1};
            5'd6:    s = '{Q_X, Q_Z, 1'b0, 4'd2, 1'b0, 1'b1};
            5'd7:    s = '{Q_W, Q_Y, 1'b1, 4'd2, 1'b1, 1'b1};
            5'd8:    s = '{Q_X, Q_Y, 1'b0, 4'd3, 1'b0, 1'b1};
            5'd9:    s = '{Q_W, Q_Z, 1'b1, 4'd3, 1'b1, 1'b1};
            5'd10:   s = '{Q_W, Q_W, 1'b0, 4'd4, 1'b0, 1'b0};
            5'd11:   s = '{Q_X, Q_X, 1'b1, 4'd4, 1'b0, 1'b0};
            5'd12:   s = '{Q_Y, Q_Y, 1'b0, 4'd4, 1'b0, 1'b0};
            5'd13:   s = '{Q_Z, Q_Z, 1'b1, 4'd4, 1'b1, 1'b0};
            5'd14:   s = '{Q_Y, Q_Z, 1'b0, 4'd5, 1'b0, 1'b1};
            5'd15:   s = '{Q_W, Q_X, 1'b0, 4'd5, 1'b1, 1'b1};
            5'd16:   s = '{Q_X, Q_Z, 1'b0, 4'd6, 1'b0, 1'b1};
            5'd17:   s = '{Q_W, Q_Y, 1'b0, 4'd6, 1'b1, 1'b1};
            5'd18:   s = '{Q_Y, Q_Z, 1'b0, 4'd7, 1'b0, 1'b1};
            5'd19:   s = '{Q_W, Q_X, 1'b1, 4'd7, 1'b1, 1'b1};
            5'd20:   s = '{Q_W, Q_W, 1'b0, 4'd8, 1'b0, 1'b0};
            5'd21:   s = '{Q_X, Q_X, 1'b1, 4'd8, 1'b0, 1'b0};
            5'd22:   s = '{Q_Y, Q_Y, 1'b1, 4'd8, 1'b0, 1'b0};
            5'd23:   s = '{Q_Z, Q_Z, 1'b0, 4'd8, 1'b1, 1'b0};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

### hdl/rpa_mat.sv
module rpa_mat import rpa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_quat i_quat,
    input  logic  i_restart,
    output t_mat  o_mat,
    output logic  o_busy
);

    logic               r_run;
    logic [4:0]         r_step;
    logic signed [63:0] r_prod;
    t_mstep             r_pctl;
    logic               r_pv;
    logic signed [65:0] r_acc;
    t_mat               r_mat;

    t_mstep             step;
    logic signed [31:0] qa;
    logic signed [31:0] qb;
    logic signed [63:0] prod;
    logic signed [65:0] term;
    logic signed [65:0] psum;
    logic signed [66:0] tot;
    logic signed [66:0] rnd;

    always_comb begin
        step = mat_step(r_step);
        qa   = i_quat[step.sel_a];
        qb   = i_quat[step.sel_b];
        prod = qa * qb;
        term = r_pctl.neg ? -66'(r_prod) : 66'(r_prod);
        psum = r_acc + term;
        tot  = r_pctl.twice ? {psum, 1'b0} : 67'(psum);
        // Round half up from Q.60 to Q.30.
        rnd  = tot + 67'sd536870912;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_run  <= 1'b1;
            r_step <= '0;
            r_pv   <= 1'b0;
            r_acc  <= '0;
        end else begin
            if (r_run) begin
                r_step <= r_step + 5'd1;
                if (r_step == MAT_LAST) begin
                    r_run <= 1'b0;
                end
            end
            r_pv <= r_run;
            if (r_pv) begin
                r_acc <= r_pctl.last ? '0 : psum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_pctl <= step;
        if (r_pv && r_pctl.last && !i_restart) begin
            r_mat[r_pctl.idx] <= rnd[COEF_W+29:30];
        end
    end

    assign o_mat  = r_mat;
    assign o_busy = r_run | r_pv;

endmodule

### hdl/rpa_front.sv
module rpa_front import rpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic        i_last_point,
    input  logic [31:0] i_offset_x,
    input  logic [31:0] i_offset_y,
    input  logic [31:0] i_offset_z,
    input  logic        i_hold,
    input  logic        i_pop,
    output t_q_head     o_head
);

    t_sum_item  r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    t_sum_item  item;
    logic       push_ok;
    logic       pop_ok;

    // Sums are kept at full 33-bit width, so nothing wraps here.
    always_comb begin
        item.s_x  = {i_point_x[31], i_point_x} + {i_offset_x[31], i_offset_x};
        item.s_y  = {i_point_y[31], i_point_y} + {i_offset_y[31], i_offset_y};
        item.s_z  = {i_point_z[31], i_point_z} + {i_offset_z[31], i_offset_z};
        item.last = i_last_point;
    end

    assign o_full  = (r_cnt == 2'd2) || i_hold;
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= item;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rp];

endmodule

### hdl/rpa_back.sv
module rpa_back import rpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_q_head i_head,
    output logic    o_pop,
    input  t_mat    i_mat,
    input  logic    i_out_pop,
    output logic    o_out_valid,
    output t_box    o_box
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [2:0]         r_cnt;
    logic [32:0]        r_sv [3];
    logic               r_last;
    logic signed [52:0] r_prod [3];
    logic               r_phi;
    logic               r_pv;
    logic signed [71:0] r_acc [3];
    logic [31:0]        r_rot [3];
    logic [31:0]        r_min [3];
    logic [31:0]        r_max [3];
    t_box               r_out;
    logic               r_out_v;

    logic               start;
    logic               upd_go;
    logic               upd_fire;
    logic               issue;
    logic [1:0]         sel_j;
    logic signed [16:0] opnd;
    logic [3:0]         ci [3];
    logic signed [35:0] coef [3];
    logic signed [52:0] prod [3];
    logic signed [71:0] addend [3];
    logic signed [71:0] rnd [3];
    logic [41:0]        rr [3];
    logic [31:0]        sat [3];
    logic [31:0]        new_min [3];
    logic [31:0]        new_max [3];

    // A last point may only finish once the result register is free.
    assign upd_go = !r_last || !r_out_v || i_out_pop;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    n_state = BK_MUL;
                end
            end
            BK_MUL: begin
                if (r_cnt == 3'd6) begin
                    n_state = BK_RND;
                end
            end
            BK_RND: n_state = BK_UPD;
            BK_UPD: begin
                if (upd_go) begin
                    n_state = i_head.valid ? BK_MUL : BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        start    = 1'b0;
        upd_fire = 1'b0;
        issue    = 1'b0;
        unique case (r_state)
            BK_IDLE: start = i_head.valid;
            BK_MUL:  issue = (r_cnt != 3'd6);
            BK_RND:  ;
            BK_UPD: begin
                upd_fire = upd_go;
                start    = upd_go && i_head.valid;
            end
            default: ;
        endcase
    end

    assign o_pop = start;

    // Each lane forms one rotated axis: three coefficients times the low
    // and high halves of each sum, one partial product per cycle.
    always_comb begin
        sel_j = (r_cnt[2:1] == 2'd3) ? 2'd2 : r_cnt[2:1];
        if (r_cnt[0]) begin
            opnd = $signed(r_sv[sel_j][32:16]);
        end else begin
            opnd = $signed({1'b0, r_sv[sel_j][15:0]});
        end
        for (int l = 0; l < 3; l++) begin
            ci[l]      = 4'(l * 3) + {2'b00, sel_j};
            coef[l]    = $signed(i_mat[ci[l]]);
            prod[l]    = coef[l] * opnd;
            addend[l]  = r_phi ? (72'(r_prod[l]) <<< 16) : 72'(r_prod[l]);
            rnd[l]     = r_acc[l] + 72'sd536870912;
            rr[l]      = rnd[l][71:30];
            if (&rr[l][41:31] || ~|rr[l][41:31]) begin
                sat[l] = rr[l][31:0];
            end else begin
                sat[l] = rr[l][41] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            new_min[l] = ($signed(r_rot[l]) < $signed(r_min[l])) ? r_rot[l] : r_min[l];
            new_max[l] = ($signed(r_rot[l]) > $signed(r_max[l])) ? r_rot[l] : r_max[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_out_v <= 1'b0;
            for (int l = 0; l < 3; l++) begin
                r_min[l] <= 32'h7FFF_FFFF;
                r_max[l] <= 32'h8000_0000;
            end
        end else begin
            r_state <= n_state;
            r_pv    <= issue;
            if (start) begin
                r_cnt <= '0;
            end else if (r_state == BK_MUL) begin
                r_cnt <= r_cnt + 3'd1;
            end
            if (upd_fire) begin
                for (int l = 0; l < 3; l++) begin
                    r_min[l] <= r_last ? 32'h7FFF_FFFF : new_min[l];
                    r_max[l] <= r_last ? 32'h8000_0000 : new_max[l];
                end
            end
            if (upd_fire && r_last) begin
                r_out_v <= 1'b1;
            end else if (i_out_pop && r_out_v) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_sv[0] <= i_head.item.s_x;
            r_sv[1] <= i_head.item.s_y;
            r_sv[2] <= i_head.item.s_z;
            r_last  <= i_head.item.last;
        end
        r_phi <= r_cnt[0];
        for (int l = 0; l < 3; l++) begin
            r_prod[l] <= prod[l];
            if (start) begin
                r_acc[l] <= '0;
            end else if (r_pv) begin
                r_acc[l] <= r_acc[l] + addend[l];
            end
            if (r_state == BK_RND) begin
                r_rot[l] <= sat[l];
            end
        end
        if (upd_fire && r_last) begin
            r_out.min_x <= new_min[0];
            r_out.min_y <= new_min[1];
            r_out.min_z <= new_min[2];
            r_out.max_x <= new_max[0];
            r_out.max_y <= new_max[1];
            r_out.max_z <= new_max[2];
        end
    end

    assign o_out_valid = r_out_v;
    assign o_box       = r_out;

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head.valid)
        else $error("sum queue popped while empty");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_MUL) |-> (r_cnt <= 3'd6))
        else $error("multiply step count out of range");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_fire && r_last) |=> r_out_v)
        else $error("last point did not produce a box");

    a_acc_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == BK_MUL))
        else $error("partial product accumulated outside the multiply phase");

endmodule

### hdl/rotated_point_aabb_core.sv
// Bounding box of rotated points. Each pushed point has the offset added
// and is rotated by the quaternion as conj(q)*v*q; per axis the block keeps
// the running minimum and maximum, and a point flagged last pushes the box,
// including that point, as one word onto the result side and starts a new
// box. In the back end a point takes six partial products per axis through
// three 36x17 multipliers, then a rounding step and an update step; a
// two-word queue lets the front accept points meanwhile. A last point waits
// in the back end while the previous box has not been popped. After reset,
// and after every write to a quaternion register, full stays high while the
// rotation coefficients are recomputed with one shared 32x32 multiplier;
// offset writes take effect at once.
module rotated_point_aabb_core import rpa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_point_x,
    input  logic [31:0] i_point_y,
    input  logic [31:0] i_point_z,
    input  logic        i_last_point,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_box_min_x,
    output logic [31:0] o_box_min_y,
    output logic [31:0] o_box_min_z,
    output logic [31:0] o_box_max_x,
    output logic [31:0] o_box_max_y,
    output logic [31:0] o_box_max_z,
    input  logic        i_cfg_wr,
    input  t_cfg_idx    i_cfg_addr,
    input  logic [31:0] i_cfg_wdata
);

    t_quat       r_quat;
    logic [31:0] r_offset_x;
    logic [31:0] r_offset_y;
    logic [31:0] r_offset_z;

    logic        quat_wr;
    logic        mat_busy;
    t_mat        mat;
    t_q_head     head;
    logic        head_pop;
    logic        out_valid;
    t_box        box;

    assign quat_wr = i_cfg_wr && ((i_cfg_addr == REG_QUAT_W) || (i_cfg_addr == REG_QUAT_X) ||
                                  (i_cfg_addr == REG_QUAT_Y) || (i_cfg_addr == REG_QUAT_Z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat     <= {32'h0, 32'h0, 32'h0, 32'h4000_0000};
            r_offset_x <= '0;
            r_offset_y <= '0;
            r_offset_z <= '0;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_addr)
                REG_QUAT_W:   r_quat[Q_W] <= i_cfg_wdata;
                REG_QUAT_X:   r_quat[Q_X] <= i_cfg_wdata;
                REG_QUAT_Y:   r_quat[Q_Y] <= i_cfg_wdata;
                REG_QUAT_Z:   r_quat[Q_Z] <= i_cfg_wdata;
                REG_OFFSET_X: r_offset_x  <= i_cfg_wdata;
                REG_OFFSET_Y: r_offset_y  <= i_cfg_wdata;
                REG_OFFSET_Z: r_offset_z  <= i_cfg_wdata;
                default:      ;
            endcase
        end
    end

    rpa_mat u_mat (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_quat    (r_quat),
        .i_restart (quat_wr),
        .o_mat     (mat),
        .o_busy    (mat_busy)
    );

    rpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_last_point (i_last_point),
        .i_offset_x   (r_offset_x),
        .i_offset_y   (r_offset_y),
        .i_offset_z   (r_offset_z),
        .i_hold       (mat_busy),
        .i_pop        (head_pop),
        .o_head       (head)
    );

    rpa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (head_pop),
        .i_mat       (mat),
        .i_out_pop   (pop),
        .o_out_valid (out_valid),
        .o_box       (box)
    );

    assign empty       = !out_valid;
    assign o_box_min_x = box.min_x;
    assign o_box_min_y = box.min_y;
    assign o_box_min_z = box.min_z;
    assign o_box_max_x = box.max_x;
    assign o_box_max_y = box.max_y;
    assign o_box_max_z = box.max_z;

endmodule
